FILE: rtl/cfc_pkg.sv
// Shared types, constants and CRC function for the CRC-16 frame checker.
`timescale 1ns / 1ps

package cfc_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 128;
  localparam int MIN_FRAME_BYTES     = 4;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [7:0]  START_RESET = 8'hF0;
  localparam logic [7:0]  COUNT_SAT   = 8'hFF;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_START = 3'd2;
  localparam logic [2:0] ST_LEN       = 3'd3;
  localparam logic [2:0] ST_CRC       = 3'd4;
  localparam logic [2:0] ST_LONG      = 3'd5;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } cfc_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       frame_done;
    logic [2:0] frame_status;
    logic [7:0] frame_type;
    logic [7:0] payload_count;
  } cfc_result_t;

  // Reflected CRC-16/MODBUS, one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/cfc_in_stage.sv
// Input register stage of the CRC-16 frame checker.
`timescale 1ns / 1ps

module cfc_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte_in,
  input  logic              in_last_byte,
  input  logic              dn_ready,
  output logic              item_valid,
  output cfc_pkg::cfc_item_t item
);

  logic               valid_r;
  cfc_pkg::cfc_item_t item_r;
  logic               load;

  // stage frees up when empty or when its item moves on
  assign in_stall   = valid_r && !dn_ready;
  assign load       = in_valid && !in_stall;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.byte_in   <= in_byte_in;
      item_r.last_byte <= in_last_byte;
    end
  end

endmodule

FILE: rtl/cfc_core.sv
// Frame state, CRC update and verdict logic of the CRC-16 frame checker.
`timescale 1ns / 1ps

module cfc_core #(
  parameter int MAX_FRAME_BYTES = cfc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_start_byte,
  input  logic                 fire,
  input  cfc_pkg::cfc_item_t   item,
  output cfc_pkg::cfc_result_t result
);

  localparam logic [7:0] MAX_POS = 8'(MAX_FRAME_BYTES);

  logic [7:0]  start_r;
  logic [7:0]  d0_r, d1_r;
  logic [7:0]  count_r;
  logic [15:0] crc_r;
  logic [7:0]  first_r, len_r, type_r;

  logic [7:0]  first_nxt, len_nxt, type_nxt, count_nxt;
  logic [15:0] crc_nxt;
  logic        hashing;
  logic [15:0] rx_crc;
  logic [2:0]  status;

  assign hashing   = count_r >= 8'd2;
  assign crc_nxt   = hashing ? cfc_pkg::crc_byte(crc_r, d1_r) : crc_r;
  assign first_nxt = (count_r == 8'd0) ? item.byte_in : first_r;
  assign len_nxt   = (count_r == 8'd1) ? item.byte_in : len_r;
  assign type_nxt  = (count_r == 8'd2) ? item.byte_in : type_r;
  assign count_nxt = (count_r == cfc_pkg::COUNT_SAT) ? count_r : count_r + 8'd1;
  assign rx_crc    = {item.byte_in, d0_r};

  always_comb begin
    if (count_r < 8'(cfc_pkg::MIN_FRAME_BYTES - 1)) begin
      status = cfc_pkg::ST_SHORT;
    end else if (count_r >= MAX_POS) begin
      status = cfc_pkg::ST_LONG;
    end else if (first_nxt != start_r) begin
      status = cfc_pkg::ST_BAD_START;
    end else if (len_nxt != count_r - 8'd1) begin
      status = cfc_pkg::ST_LEN;
    end else if (rx_crc != crc_nxt) begin
      status = cfc_pkg::ST_CRC;
    end else begin
      status = cfc_pkg::ST_OK;
    end
  end

  always_comb begin
    result.payload_byte  = hashing ? d1_r : 8'd0;
    result.payload_valid = count_r >= 8'd5;
    result.frame_done    = item.last_byte;
    result.frame_status  = item.last_byte ? status : cfc_pkg::ST_OK;
    result.frame_type    = item.last_byte ? type_nxt : 8'd0;
    result.payload_count = (item.last_byte && len_nxt >= 8'd3) ? len_nxt - 8'd3 : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= cfc_pkg::START_RESET;
    end else if (cfg_we) begin
      start_r <= cfg_start_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d0_r    <= 8'd0;
      d1_r    <= 8'd0;
      count_r <= 8'd0;
      crc_r   <= cfc_pkg::CRC_INIT;
      first_r <= 8'd0;
      len_r   <= 8'd0;
      type_r  <= 8'd0;
    end else if (fire) begin
      if (item.last_byte) begin
        d0_r    <= 8'd0;
        d1_r    <= 8'd0;
        count_r <= 8'd0;
        crc_r   <= cfc_pkg::CRC_INIT;
        first_r <= 8'd0;
        len_r   <= 8'd0;
        type_r  <= 8'd0;
      end else begin
        d0_r    <= item.byte_in;
        d1_r    <= d0_r;
        count_r <= count_nxt;
        crc_r   <= crc_nxt;
        first_r <= first_nxt;
        len_r   <= len_nxt;
        type_r  <= type_nxt;
      end
    end
  end

endmodule

FILE: rtl/cfc_out_stage.sv
// Result register stage of the CRC-16 frame checker.
`timescale 1ns / 1ps

module cfc_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  cfc_pkg::cfc_result_t result,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cfc_pkg::cfc_result_t out_result
);

  logic                 valid_r;
  cfc_pkg::cfc_result_t result_r;

  assign ready      = !valid_r || !out_stall;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      result_r <= result;
    end
  end

endmodule

FILE: rtl/crc16_frame_checker.sv
// Top level of the CRC-16/MODBUS frame checker.
`timescale 1ns / 1ps

// Channel   Ports                                  Direction  Moves
// in        in_valid/in_stall, in_byte_in, ...     receive    one byte per transfer
// out       out_valid/out_stall, out_payload_byte  send       one result per input byte
// cfg       cfg_we, cfg_start_byte                 receive    start byte value
//
// Each byte passes the input register, then CRC/verdict logic into the result register.
// One byte per cycle sustained while out_stall is low; the byte-wide CRC update is one unrolled step per byte.
// rst_n is synchronous, active low; clears frame state, CRC to 0xFFFF, start byte to 0xF0.
// out_stall holds the result register, and the input register then raises in_stall.
// Frame state is cleared after every byte marked last.

module crc16_frame_checker #(
  parameter int MAX_FRAME_BYTES = cfc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_we,
  input  logic [7:0] cfg_start_byte,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_in,
  input  logic       in_last_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_payload_valid,
  output logic       out_frame_done,
  output logic [2:0] out_frame_status,
  output logic [7:0] out_frame_type,
  output logic [7:0] out_payload_count
);

  logic                 item_valid;
  cfc_pkg::cfc_item_t   item;
  logic                 out_ready;
  logic                 fire;
  cfc_pkg::cfc_result_t result;
  cfc_pkg::cfc_result_t out_result;

  // a byte is processed when it leaves the input register into the result register
  assign fire = item_valid && out_ready;

  cfc_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte_in   (in_byte_in),
    .in_last_byte (in_last_byte),
    .dn_ready     (out_ready),
    .item_valid   (item_valid),
    .item         (item)
  );

  cfc_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_start_byte (cfg_start_byte),
    .fire           (fire),
    .item           (item),
    .result         (result)
  );

  cfc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (item_valid),
    .result     (result),
    .ready      (out_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign out_payload_byte  = out_result.payload_byte;
  assign out_payload_valid = out_result.payload_valid;
  assign out_frame_done    = out_result.frame_done;
  assign out_frame_status  = out_result.frame_status;
  assign out_frame_type    = out_result.frame_type;
  assign out_payload_count = out_result.payload_count;

  // ---------------------------------------------------------------- assertions

  // with the result side free, the input side never stalls
  a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("in_stall raised while out_stall low");

  // verdict fields only carry data on a frame's last byte
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_frame_done) |->
      (out_frame_status == cfc_pkg::ST_OK && out_frame_type == 8'd0 &&
       out_payload_count == 8'd0))
    else $error("verdict fields set on a non-final byte");

  // a frame accepted as ok fits within the maximum frame size
  a_ok_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done && out_frame_status == cfc_pkg::ST_OK) |->
      (out_payload_count <= 8'(MAX_FRAME_BYTES - 5)))
    else $error("ok verdict with payload count beyond frame limit");

  // status code stays within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_status <= cfc_pkg::ST_LONG))
    else $error("undefined frame status");

endmodule
